>>> sv/b64d_pkg.sv
package b64d_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Register indexes
  localparam int unsigned REG_OUT_CAPACITY = 0;

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // Character codes with special meaning
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;

  // One result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [15:0] byte_count;
    logic        last;
  } result_t;

  // Alphabet lookup: valid flag in bit 6, sextet in bits 5:0
  function automatic logic [6:0] map_sextet(input logic [7:0] ch);
    logic [6:0] res;
    res = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      res = {1'b1, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      res = {1'b1, 6'(ch - 8'h61) + SEXTET_LOWER};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, 6'(ch - 8'h30) + SEXTET_DIGIT};
    end else if (ch == 8'h2B) begin
      res = {1'b1, SEXTET_PLUS};
    end else if (ch == 8'h2F) begin
      res = {1'b1, SEXTET_SLASH};
    end
    return res;
  endfunction

endpackage

>>> sv/base64_stream_decoder_core.sv
// Base64 stream decoder (standard alphabet). One character is taken per request; whitespace is
// skipped, each group of four sextets yields three data bytes, '=' stops decoding, and the
// end-of-text request flushes a tail of two or three sextets, then reports finish or error with
// the byte count and re-arms, or only re-arms after an error. The input side takes one request
// per cycle; the decoded results of a request go into a three-entry pending buffer and leave
// through the output register at one result per cycle while the output is not stalled; the
// input stalls only while earlier results still wait in the pending buffer. The output capacity
// register (APB, byte address 0, reset 65535) limits the decoded bytes of one text; write it only
// while the block is idle.
module base64_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  kind_o,
  output logic [15:0] byte_count_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    PH_DECODE = 2'd0,
    PH_STOP   = 2'd1,
    PH_ERROR  = 2'd2
  } phase_e;

  logic [15:0] capacity_q;
  logic [5:0]  store_q [3];
  logic [5:0]  store_d [3];
  logic [1:0]  scount_q, scount_d;
  logic [15:0] bytes_q, bytes_d;
  phase_e      phase_q, phase_d;

  b64d_pkg::result_t pend_q [3];
  b64d_pkg::result_t pend_d [3];
  logic [1:0]  pend_cnt_q, pend_cnt_d;
  logic [1:0]  new_cnt;

  b64d_pkg::result_t out_q;
  logic        out_valid_q;

  logic        out_free, accept, cfg_write, reg_sel;

  // Config port
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[2] == 1'(b64d_pkg::REG_OUT_CAPACITY));
  assign cfg_write = psel && penable && pwrite && reg_sel;
  assign prdata    = reg_sel ? {16'd0, capacity_q} : 32'd0;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((pend_cnt_q == 2'd0) || ((pend_cnt_q == 2'd1) && out_free));
  assign accept     = in_valid_i && !in_stall_o;

  // Decode one request against current state
  always_comb begin
    logic [6:0]  map;
    logic [16:0] sum3;
    logic [15:0] cnt;
    logic        failed;
    logic [7:0]  b0, b1, b2;
    logic        ws;
    b64d_pkg::result_t r;

    map    = b64d_pkg::map_sextet(char_code_i);
    sum3   = {1'b0, bytes_q} + 17'd3;
    cnt    = bytes_q;
    failed = 1'b0;
    ws     = (char_code_i == b64d_pkg::CHAR_SPACE) || (char_code_i == b64d_pkg::CHAR_TAB) ||
             (char_code_i == b64d_pkg::CHAR_CR) || (char_code_i == b64d_pkg::CHAR_LF);
    b0     = {store_q[0], store_q[1][5:4]};
    b1     = {store_q[1][3:0], store_q[2][5:2]};
    b2     = {store_q[2][1:0], map[5:0]};

    store_d  = store_q;
    scount_d = scount_q;
    bytes_d  = bytes_q;
    phase_d  = phase_q;
    new_cnt  = 2'd0;
    r        = '0;
    for (int i = 0; i < 3; i++) begin
      pend_d[i] = r;
    end

    if (end_of_text_i) begin
      // flush tail, then finish or error
      if (phase_q != PH_ERROR) begin
        if (scount_q >= 2'd2) begin
          if (cnt >= capacity_q) begin
            failed = 1'b1;
          end else begin
            cnt = cnt + 16'd1;
            pend_d[new_cnt] = '{out_byte: b0, kind: b64d_pkg::KIND_DATA,
                                byte_count: cnt, last: 1'b0};
            new_cnt = new_cnt + 2'd1;
          end
        end
        if (!failed && scount_q == 2'd3) begin
          if (cnt >= capacity_q) begin
            failed = 1'b1;
          end else begin
            cnt = cnt + 16'd1;
            pend_d[new_cnt] = '{out_byte: b1, kind: b64d_pkg::KIND_DATA,
                                byte_count: cnt, last: 1'b0};
            new_cnt = new_cnt + 2'd1;
          end
        end
        pend_d[new_cnt] = '{out_byte: 8'd0,
                            kind: failed ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_DONE,
                            byte_count: cnt, last: 1'b1};
        new_cnt = new_cnt + 2'd1;
      end
      scount_d = 2'd0;
      bytes_d  = 16'd0;
      phase_d  = PH_DECODE;
    end else if (phase_q == PH_DECODE && !ws) begin
      if (char_code_i == b64d_pkg::CHAR_PAD) begin
        phase_d = PH_STOP;
      end else if (!map[6]) begin
        // bad character
        phase_d   = PH_ERROR;
        pend_d[0] = '{out_byte: 8'd0, kind: b64d_pkg::KIND_ERR, byte_count: bytes_q, last: 1'b1};
        new_cnt   = 2'd1;
      end else if (scount_q != 2'd3) begin
        case (scount_q)
          2'd0:    store_d[0] = map[5:0];
          2'd1:    store_d[1] = map[5:0];
          default: store_d[2] = map[5:0];
        endcase
        scount_d = scount_q + 2'd1;
      end else if (sum3 > {1'b0, capacity_q}) begin
        // group overflow
        phase_d   = PH_ERROR;
        pend_d[0] = '{out_byte: 8'd0, kind: b64d_pkg::KIND_ERR, byte_count: bytes_q, last: 1'b1};
        new_cnt   = 2'd1;
      end else begin
        pend_d[0] = '{out_byte: b0, kind: b64d_pkg::KIND_DATA,
                      byte_count: bytes_q + 16'd1, last: 1'b0};
        pend_d[1] = '{out_byte: b1, kind: b64d_pkg::KIND_DATA,
                      byte_count: bytes_q + 16'd2, last: 1'b0};
        pend_d[2] = '{out_byte: b2, kind: b64d_pkg::KIND_DATA,
                      byte_count: sum3[15:0], last: 1'b0};
        new_cnt   = 2'd3;
        bytes_d   = sum3[15:0];
        scount_d  = 2'd0;
      end
    end
  end

  // Pending count: load on request, drain one per output move
  always_comb begin
    pend_cnt_d = pend_cnt_q;
    if (accept) begin
      pend_cnt_d = new_cnt;
    end else if (out_free && pend_cnt_q != 2'd0) begin
      pend_cnt_d = pend_cnt_q - 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= b64d_pkg::CAPACITY_RESET;
      scount_q    <= 2'd0;
      bytes_q     <= 16'd0;
      phase_q     <= PH_DECODE;
      pend_cnt_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity_q <= pwdata[15:0];
      end
      if (accept) begin
        scount_q <= scount_d;
        bytes_q  <= bytes_d;
        phase_q  <= phase_d;
      end
      pend_cnt_q <= pend_cnt_d;
      if (out_free) begin
        out_valid_q <= (pend_cnt_q != 2'd0);
      end
    end
  end

  // Payload: sextet store, pending buffer, output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q <= store_d;
      pend_q  <= pend_d;
    end else if (out_free && pend_cnt_q != 2'd0) begin
      pend_q[0] <= pend_q[1];
      pend_q[1] <= pend_q[2];
    end
    if (out_free) begin
      out_q <= pend_q[0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_q.out_byte;
  assign kind_o       = out_q.kind;
  assign byte_count_o = out_q.byte_count;
  assign last_o       = out_q.last;

endmodule
